// File: rtl/wmsm_pkg.sv
// Package for the weighted max splat map unit: sizes, payload structs,
// controller/datapath interface structs and the falloff ROM contents.
// No dependencies.
package wmsm_pkg;

  localparam int MAP_WIDTH      = 256;
  localparam int MAP_HEIGHT     = 256;
  localparam int RADIUS_MAX     = 3;
  localparam int CAM_COORD_BITS = 12;

  localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int X_W       = $clog2(MAP_WIDTH);
  localparam int Y_W       = $clog2(MAP_HEIGHT);
  localparam int XS_W      = $clog2(MAP_WIDTH + 1);
  localparam int YS_W      = $clog2(MAP_HEIGHT + 1);
  // effective active sizes, wide enough for both the register and the map size
  localparam int AW_W      = (XS_W > 9) ? XS_W : 9;
  localparam int AH_W      = (YS_W > 9) ? YS_W : 9;
  localparam int NX_W      = AW_W + 1;
  localparam int NY_W      = AH_W + 1;
  localparam int R_W       = $clog2(RADIUS_MAX + 1);
  localparam int OFS_W     = R_W + 1;
  localparam int D2_MAX    = 2 * RADIUS_MAX * RADIUS_MAX;
  localparam int D2_W      = $clog2(D2_MAX + 1);
  localparam int ROM_DEPTH = (RADIUS_MAX + 1) * (D2_MAX + 1);
  localparam int ROM_IDX_W = $clog2(ROM_DEPTH);
  localparam int ROM_BITS  = ROM_DEPTH * 16;

  localparam logic [11:0] CAM_MASK =
    (CAM_COORD_BITS >= 12) ? 12'hFFF : 12'((1 << CAM_COORD_BITS) - 1);
  localparam logic [15:0] CONF_ONE = 16'd32768;

  // operation codes
  localparam logic OP_SPLAT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SPLAT_RADIUS  = 2'd2;

  typedef struct packed {
    logic        op;
    logic [11:0] cam_x;
    logic [11:0] cam_y;
    logic [15:0] sample_confidence;
    logic [15:0] proj_x;
    logic [15:0] proj_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] best_confidence;
    logic [11:0] best_cam_x;
    logic [11:0] best_cam_y;
    logic        in_range;
  } out_item_t;

  typedef struct packed {
    logic [15:0] score;
    logic [11:0] col;
    logic [11:0] row;
  } map_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLAT,
    ST_DRAIN,
    ST_READ,
    ST_RDATA
  } ctrl_state_t;

  typedef struct packed {
    logic clear_en;
    logic item_load;
    logic scan_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  // r/(r+sqrt(d2)) in Q1.15, nearest with ties up; entry index r*(D2_MAX+1)+d2
  function automatic logic [ROM_BITS-1:0] build_falloff_rom();
    logic [ROM_BITS-1:0] rom;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] odd;
    logic [63:0] lhs;
    rom = '0;
    for (int r = 0; r <= RADIUS_MAX; r++) begin
      for (int d2 = 0; d2 <= D2_MAX; d2++) begin
        lo = 64'd1;
        hi = 64'd32768;
        if (r == 0) begin
          lo = 64'd0;
        end else begin
          for (int k = 0; k < 16; k++) begin
            if (lo < hi) begin
              mid = (lo + hi + 64'd1) >> 1;
              odd = (mid << 1) - 64'd1;
              lhs = 64'(r) * (64'd65536 - odd);
              if (lhs * lhs >= odd * odd * 64'(d2)) begin
                lo = mid;
              end else begin
                hi = mid - 64'd1;
              end
            end
          end
        end
        rom[(r * (D2_MAX + 1) + d2) * 16 +: 16] = lo[15:0];
      end
    end
    return rom;
  endfunction

  localparam logic [ROM_BITS-1:0] FALLOFF_ROM = build_falloff_rom();

endpackage

// File: rtl/weighted_max_splat_map_unit.sv
// Top level of the weighted max splat map unit: joins controller and datapath.
// Depends on wmsm_pkg, wmsm_ctrl and wmsm_dp.
//
// Builds a projector-to-camera map by weighted maximum splatting. After reset
// a clearing pass zeroes the map, one entry a cycle, during which no item is
// taken; configuration writes are taken at all times and should be made only
// while the unit is idle. A splat walks its (2r+1) x (2r+1) window one
// neighbour a cycle through the read port and the write port of the map
// memory (read, multiply, compare-and-write in a three-stage pipeline),
// followed by a drain state; a splat outside the active size takes the same
// time and changes nothing. A read registers the item, reads the map entry and
// loads the result into an output register, where it is held so the next item
// can be accepted while it waits.
module weighted_max_splat_map_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wmsm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output wmsm_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data
);
  import wmsm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  wmsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wmsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // no transaction is taken while the map is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_en |-> !in_ready)
    else $error("input accepted during clearing pass");

  // a splat never produces a result
  a_splat_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.op == OP_SPLAT) |=> ##1 !$rose(out_valid))
    else $error("result raised by a splat");

  // the drain state separates a scan step from the next accept
  a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_en |=> !in_ready)
    else $error("input accepted before splat pipeline drained");

  // a result appears only by a load from the controller
  a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result without load command");

endmodule

// File: rtl/wmsm_ctrl.sv
// Controller for the weighted max splat map unit: clearing pass, splat scan
// and read sequencing. Depends on wmsm_pkg.
module wmsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  wmsm_pkg::dp_status_t status,
  output wmsm_pkg::ctrl_cmd_t  cmd
);
  import wmsm_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (status.clear_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_op == OP_READ) ? ST_READ : ST_SPLAT;
      end
      ST_SPLAT: if (status.scan_last) state_nxt = ST_DRAIN;
      // last write lands in the idle cycle after this one, ahead of any read
      // for the next transaction
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_RDATA;
      ST_RDATA: if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: cmd.clear_en = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.item_load = in_valid;
      end
      ST_SPLAT: cmd.scan_en  = 1'b1;
      ST_DRAIN: ;
      ST_READ:  ;
      ST_RDATA: cmd.out_load = status.out_free;
      default:  ;
    endcase
  end

endmodule

// File: rtl/wmsm_dp.sv
// Datapath for the weighted max splat map unit: configuration registers, item
// registers, neighbour scan, score pipeline, map memory and output register.
// Depends on wmsm_pkg.
module wmsm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wmsm_pkg::ctrl_cmd_t  cmd,
  output wmsm_pkg::dp_status_t status,
  input  wmsm_pkg::in_item_t   in_item,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [8:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wmsm_pkg::out_item_t  out_item
);
  import wmsm_pkg::*;

  // configuration
  logic [8:0] active_width_r, active_height_r;
  logic [1:0] splat_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= 9'd256;
      active_height_r <= 9'd256;
      splat_radius_r  <= 2'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH:  active_width_r  <= cfg_data;
        REG_ACTIVE_HEIGHT: active_height_r <= cfg_data;
        REG_SPLAT_RADIUS:  splat_radius_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [AW_W-1:0] aw;
  logic [AH_W-1:0] ah;
  logic [2:0]      rad_tmp;
  logic [R_W-1:0]  rad_eff;
  logic            inside_in;

  always_comb begin
    aw = (AW_W'(active_width_r) > AW_W'(MAP_WIDTH)) ? AW_W'(MAP_WIDTH)
                                                     : AW_W'(active_width_r);
    ah = (AH_W'(active_height_r) > AH_W'(MAP_HEIGHT)) ? AH_W'(MAP_HEIGHT)
                                                       : AH_W'(active_height_r);
    rad_tmp = (splat_radius_r == 2'd0) ? 3'd1 : {1'b0, splat_radius_r};
    rad_eff = (rad_tmp > 3'(RADIUS_MAX)) ? R_W'(RADIUS_MAX) : R_W'(rad_tmp);
    inside_in = (in_item.proj_x < 16'(aw)) && (in_item.proj_y < 16'(ah));
  end

  // item registers
  logic [X_W-1:0]   px_r;
  logic [Y_W-1:0]   py_r;
  logic             inside_r;
  logic [15:0]      conf_r;
  logic [11:0]      cx_r, cy_r;
  logic [R_W-1:0]   r_r;
  logic signed [OFS_W-1:0] ox_r, oy_r;
  logic signed [OFS_W-1:0] r_s;

  assign r_s = signed'({1'b0, r_r});

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      px_r     <= in_item.proj_x[X_W-1:0];
      py_r     <= in_item.proj_y[Y_W-1:0];
      inside_r <= inside_in;
      conf_r   <= (in_item.sample_confidence > CONF_ONE) ? CONF_ONE
                                                         : in_item.sample_confidence;
      cx_r     <= in_item.cam_x & CAM_MASK;
      cy_r     <= in_item.cam_y & CAM_MASK;
      r_r      <= rad_eff;
      ox_r     <= -signed'({1'b0, rad_eff});
      oy_r     <= -signed'({1'b0, rad_eff});
    end else if (cmd.scan_en) begin
      if (ox_r == r_s) begin
        ox_r <= -r_s;
        oy_r <= oy_r + OFS_W'(1);
      end else begin
        ox_r <= ox_r + OFS_W'(1);
      end
    end
  end

  assign status.scan_last = (ox_r == r_s) && (oy_r == r_s);

  // neighbour of the current offset
  logic signed [NX_W-1:0] nx;
  logic signed [NY_W-1:0] ny;
  logic                   nb_ok;
  logic [ADDR_W-1:0]      nb_addr;
  logic [ADDR_W-1:0]      item_addr;
  logic [R_W-1:0]         ax, ay;
  logic [D2_W-1:0]        d2;
  logic [ROM_IDX_W-1:0]   rom_idx;

  always_comb begin
    nx = signed'(NX_W'(px_r)) + NX_W'(ox_r);
    ny = signed'(NY_W'(py_r)) + NY_W'(oy_r);
    nb_ok = inside_r && !nx[NX_W-1] && !ny[NY_W-1] &&
            (nx[AW_W-1:0] < aw) && (ny[AH_W-1:0] < ah);
    nb_addr = ADDR_W'(ny[Y_W-1:0]) * ADDR_W'(MAP_WIDTH) + ADDR_W'(nx[X_W-1:0]);
    item_addr = ADDR_W'(py_r) * ADDR_W'(MAP_WIDTH) + ADDR_W'(px_r);
    ax = ox_r[OFS_W-1] ? R_W'(-ox_r) : R_W'(ox_r);
    ay = oy_r[OFS_W-1] ? R_W'(-oy_r) : R_W'(oy_r);
    d2 = D2_W'(ax) * D2_W'(ax) + D2_W'(ay) * D2_W'(ay);
    rom_idx = ROM_IDX_W'(r_r) * ROM_IDX_W'(D2_MAX + 1) + ROM_IDX_W'(d2);
  end

  // map memory, registered read
  map_entry_t        mem [MAP_DEPTH];
  map_entry_t        rdata_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  map_entry_t        wr_data;
  logic [ADDR_W-1:0] clr_cnt_r;

  // score pipeline: lookup, multiply, compare and write
  logic              s1_valid_r, s2_valid_r;
  logic [ADDR_W-1:0] s1_addr_r, s2_addr_r;
  logic [15:0]       s1_fall_r;
  logic [15:0]       s2_score_r, s2_old_r;
  logic [31:0]       product;

  assign rd_addr = cmd.scan_en ? nb_addr : item_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_en) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      s1_valid_r <= cmd.scan_en && nb_ok;
      s2_valid_r <= s1_valid_r;
    end
  end

  assign status.clear_last = (clr_cnt_r == ADDR_W'(MAP_DEPTH - 1));
  assign product = s1_fall_r * conf_r;

  always_ff @(posedge clk) begin
    s1_addr_r  <= nb_addr;
    s1_fall_r  <= FALLOFF_ROM[rom_idx * 16 +: 16];
    s2_addr_r  <= s1_addr_r;
    s2_score_r <= product[30:15];
    s2_old_r   <= rdata_r.score;
  end

  always_comb begin
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = s2_valid_r && (s2_score_r > s2_old_r);
      wr_addr = s2_addr_r;
      wr_data = '{score: s2_score_r, col: cx_r, row: cy_r};
    end
  end

  // output register
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (inside_r) begin
        out_item_r <= '{best_confidence: rdata_r.score, best_cam_x: rdata_r.col,
                        best_cam_y: rdata_r.row, in_range: 1'b1};
      end else begin
        out_item_r <= '0;
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
